/* rtl/bld_pkg.sv */
// Shared types, constants and register codes for the battery level debouncer.
package bld_pkg;

  localparam int unsigned LevelW  = 3;
  localparam int unsigned ThreshW = 14;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned AdcW    = 8;

  localparam logic [ThreshW-1:0] ThreshOneRst   = 14'd6800;
  localparam logic [ThreshW-1:0] ThreshTwoRst   = 14'd7200;
  localparam logic [ThreshW-1:0] ThreshThreeRst = 14'd7400;
  localparam logic [ThreshW-1:0] ThreshFourRst  = 14'd7800;
  localparam logic [LimitW-1:0]  ConfirmRst     = 8'd255;
  localparam logic [ThreshW-1:0] ScaleFactor    = 14'd10;

  typedef logic [LevelW-1:0] level_t;

  localparam level_t LvlZero  = 3'd0;
  localparam level_t LvlOne   = 3'd1;
  localparam level_t LvlTwo   = 3'd2;
  localparam level_t LvlThree = 3'd3;
  localparam level_t LvlFour  = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshOne   = 3'd0,
    CfgThreshTwo   = 3'd1,
    CfgThreshThree = 3'd2,
    CfgThreshFour  = 3'd3,
    CfgConfirm     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ThreshW-1:0] thresh_one;
    logic [ThreshW-1:0] thresh_two;
    logic [ThreshW-1:0] thresh_three;
    logic [ThreshW-1:0] thresh_four;
    logic [LimitW-1:0]  confirm_limit;
  } cfg_t;

endpackage

/* rtl/bld_cfg.sv */
// Configuration register file: thresholds and confirm limit.
module bld_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bld_pkg::ThreshW-1:0]  cfg_data_i,
  output bld_pkg::cfg_t                cfg_o
);
  import bld_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh_one    <= ThreshOneRst;
      cfg_q.thresh_two    <= ThreshTwoRst;
      cfg_q.thresh_three  <= ThreshThreeRst;
      cfg_q.thresh_four   <= ThreshFourRst;
      cfg_q.confirm_limit <= ConfirmRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgThreshOne:   cfg_q.thresh_one    <= cfg_data_i;
        CfgThreshTwo:   cfg_q.thresh_two    <= cfg_data_i;
        CfgThreshThree: cfg_q.thresh_three  <= cfg_data_i;
        CfgThreshFour:  cfg_q.thresh_four   <= cfg_data_i;
        CfgConfirm:     cfg_q.confirm_limit <= cfg_data_i[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/bld_classify.sv */
// Scales one converter reading and maps it to a raw level against the thresholds.
module bld_classify (
  input  logic [bld_pkg::AdcW-1:0] adc_high_i,
  input  logic [bld_pkg::AdcW-1:0] adc_low_i,
  input  logic                     read_ok_i,
  input  bld_pkg::cfg_t            cfg_i,
  output bld_pkg::level_t          raw_level_o
);
  import bld_pkg::*;

  logic [AdcW+2:0]    code_p1;
  logic [ThreshW-1:0] scaled;

  assign code_p1 = {1'b0, adc_high_i, adc_low_i[AdcW-1 -: 2]} + (AdcW+3)'(1);
  assign scaled  = ThreshW'(code_p1) * ScaleFactor;

  always_comb begin
    if (!read_ok_i) begin
      raw_level_o = LvlZero;
    end else if (scaled < cfg_i.thresh_one) begin
      raw_level_o = LvlZero;
    end else if (scaled < cfg_i.thresh_two) begin
      raw_level_o = LvlOne;
    end else if (scaled < cfg_i.thresh_three) begin
      raw_level_o = LvlTwo;
    end else if (scaled < cfg_i.thresh_four) begin
      raw_level_o = LvlThree;
    end else begin
      raw_level_o = LvlFour;
    end
  end

endmodule

/* rtl/bld_debounce.sv */
// Debounce state: stable level, candidate level and agreement counter.
module bld_debounce (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        advance_i,
  input  bld_pkg::level_t             raw_level_i,
  input  logic [bld_pkg::LimitW-1:0]  confirm_limit_i,
  output bld_pkg::level_t             level_d_o
);
  import bld_pkg::*;

  level_t            stable_q, stable_d;
  level_t            cand_q;
  logic [LimitW-1:0] agree_q, agree_d;
  logic [LimitW:0]   agree_inc;

  assign agree_inc = {1'b0, agree_q} + (LimitW+1)'(1);

  always_comb begin
    stable_d = stable_q;
    agree_d  = '0;
    if (cand_q != stable_q && cand_q == raw_level_i) begin
      if (agree_inc >= {1'b0, confirm_limit_i}) begin
        stable_d = cand_q;
      end else begin
        agree_d = agree_inc[LimitW-1:0];
      end
    end
  end

  assign level_d_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= LvlZero;
      cand_q   <= LvlZero;
      agree_q  <= '0;
    end else if (advance_i) begin
      stable_q <= stable_d;
      cand_q   <= raw_level_i;
      agree_q  <= agree_d;
    end
  end

endmodule

/* rtl/battery_level_debouncer.sv */
// Top level of the battery level debouncer: input register, classify, debounce, result register.
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_stall_o    adc_high_i, adc_low_i, read_ok_i
//   out      source     out_valid_o / out_stall_i  level_o, raw_level_o
//   cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One reading per cycle unless the result stalls; the input register feeds the result register.
// The path from the input register to the result register holds the scale, the four
// threshold compares and the debounce update. Reset clears the debounce state and loads
// the default thresholds. A stalled result holds both stages; the input register still
// takes a reading while empty or draining, so one reading can wait behind a stalled result.
module battery_level_debouncer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bld_pkg::AdcW-1:0]     adc_high_i,
  input  logic [bld_pkg::AdcW-1:0]     adc_low_i,
  input  logic                         read_ok_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bld_pkg::level_t              level_o,
  output bld_pkg::level_t              raw_level_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bld_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bld_pkg::ThreshW-1:0]  cfg_data_i
);
  import bld_pkg::*;

  cfg_t            cfg;
  logic            s1_valid_q;
  logic [AdcW-1:0] s1_high_q, s1_low_q;
  logic            s1_ok_q;
  logic            out_free, s1_free, s1_advance;
  level_t          raw_level, level_d;
  level_t          level_q, raw_level_q;
  logic            out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_advance = s1_valid_q && out_free;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;

  bld_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bld_classify u_classify (
    .adc_high_i  (s1_high_q),
    .adc_low_i   (s1_low_q),
    .read_ok_i   (s1_ok_q),
    .cfg_i       (cfg),
    .raw_level_o (raw_level)
  );

  bld_debounce u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (s1_advance),
    .raw_level_i     (raw_level),
    .confirm_limit_i (cfg.confirm_limit),
    .level_d_o       (level_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_high_q <= adc_high_i;
      s1_low_q  <= adc_low_i;
      s1_ok_q   <= read_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      level_q     <= level_d;
      raw_level_q <= raw_level;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign raw_level_o = raw_level_q;

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (level_o <= LvlFour && raw_level_o <= LvlFour))
    else $error("result level out of range");

  a_failed_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && !s1_ok_q) |=> (raw_level_o == LvlZero))
    else $error("failed read did not give raw level zero");

  a_commit_agrees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && $past(out_valid_o) && !$stable(level_o)) |-> (raw_level_o == level_o))
    else $error("level changed without an agreeing reading");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_advance) |=> (s1_valid_q && $stable(s1_high_q) && $stable(s1_ok_q)))
    else $error("waiting reading lost while result stalled");

endmodule
